### sv/ksel_pkg.sv
// Shared constants, types and a compare helper for the k-smallest selection block.
package ksel_pkg;

   localparam int KEEP_COUNT = 16;
   localparam int ID_COUNT   = 4096;
   localparam int ID_W       = 13;
   localparam int WEIGHT_W   = 32;
   localparam int RANK_W     = 6;

   localparam logic [WEIGHT_W-1:0] EMPTY_WEIGHT_RESET = 32'd65536000;

   localparam int SLOT_W      = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
   localparam int CNT_W       = $clog2(KEEP_COUNT + 1);
   localparam int GROUP_SIZE  = (KEEP_COUNT > 32) ? 8 : 4;
   localparam int GROUP_COUNT = (KEEP_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Classified candidate handed from the front end to the slot engine.
   typedef struct packed {
      logic                       update;
      logic [ID_W-1:0]            id;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last;
   } cmd_type;

   // One drained slot on its way to the result queue.
   typedef struct packed {
      logic [RANK_W-1:0]          rank;
      logic [ID_W-1:0]            id;
      logic signed [WEIGHT_W-1:0] weight;
      logic                       last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_EVAL,
      ST_UPDATE,
      ST_DRAIN_SCAN,
      ST_DRAIN_PICK
   } eng_state_type;

   // Ascending order of drained slots: weight first, then identifier.
   function automatic logic key_less(input logic signed [WEIGHT_W-1:0] wa,
                                     input logic [ID_W-1:0]            ia,
                                     input logic signed [WEIGHT_W-1:0] wb,
                                     input logic [ID_W-1:0]            ib);
      logic lt;
      lt = ($signed(wa) < $signed(wb)) || ((wa == wb) && (ia < ib));
      return lt;
   endfunction

endpackage

### sv/ksel_front.sv
// Front end: classifies each candidate request and queues it for the slot engine.
module ksel_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [ksel_pkg::ID_W-1:0]           req_candidate_id,
   input  logic signed [ksel_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                                req_excluded,
   input  logic                                req_last_candidate,
   output logic                                cmd_valid,
   output ksel_pkg::cmd_type                   cmd_data,
   input  logic                                cmd_pop
);

   ksel_pkg::cmd_type                    queue_ff [ksel_pkg::CMD_DEPTH];
   logic [ksel_pkg::CMD_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ksel_pkg::CMD_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ksel_pkg::CMD_CNT_W-1:0]       count_ff, count_in;
   ksel_pkg::cmd_type                    entry;
   logic                                 id_ok;
   logic                                 push_ok;
   logic                                 pop_ok;

   // Identifier zero marks an empty slot and identifiers past the table are ignored.
   assign id_ok = (req_candidate_id != '0) &&
                  (32'(req_candidate_id) <= 32'(ksel_pkg::ID_COUNT));

   always_comb begin
      entry.update = id_ok && !req_excluded;
      entry.id     = req_candidate_id;
      entry.weight = req_weight;
      entry.last   = req_last_candidate;
   end

   assign req_full  = (count_ff == ksel_pkg::CMD_CNT_W'(ksel_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == ksel_pkg::CMD_PTR_W'(ksel_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ksel_pkg::CMD_PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == ksel_pkg::CMD_PTR_W'(ksel_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ksel_pkg::CMD_PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + ksel_pkg::CMD_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - ksel_pkg::CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### sv/ksel_engine.sv
// Slot engine: keeps the smallest-weight slots, then drains them in ascending order.
module ksel_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic signed [ksel_pkg::WEIGHT_W-1:0] csr_empty_weight,
   input  logic                                 cmd_valid,
   input  ksel_pkg::cmd_type                    cmd_data,
   output logic                                 cmd_pop,
   input  logic                                 out_full,
   output logic                                 out_push,
   output ksel_pkg::rsp_type                    out_data
);

   localparam int K = ksel_pkg::KEEP_COUNT;
   localparam int G = ksel_pkg::GROUP_COUNT;

   ksel_pkg::eng_state_type              state_ff, state_in;
   ksel_pkg::cmd_type                    op_ff, op_in;
   logic signed [ksel_pkg::WEIGHT_W-1:0] empty_weight_ff, empty_weight_in;

   logic [ksel_pkg::ID_W-1:0]            slot_id_ff [K];
   logic [ksel_pkg::ID_W-1:0]            slot_id_in [K];
   logic signed [ksel_pkg::WEIGHT_W-1:0] slot_wt_ff [K];
   logic signed [ksel_pkg::WEIGHT_W-1:0] slot_wt_in [K];
   logic [K-1:0]                         hit_ff, hit_in;
   logic [K-1:0]                         taken_ff, taken_in;
   logic [ksel_pkg::CNT_W-1:0]           cnt_ff, cnt_in;

   logic [G-1:0]                         grp_ok_ff, grp_ok_in;
   logic [ksel_pkg::SLOT_W-1:0]          grp_idx_ff [G];
   logic [ksel_pkg::SLOT_W-1:0]          grp_idx_in [G];
   logic [ksel_pkg::ID_W-1:0]            grp_id_ff  [G];
   logic [ksel_pkg::ID_W-1:0]            grp_id_in  [G];
   logic signed [ksel_pkg::WEIGHT_W-1:0] grp_wt_ff  [G];
   logic signed [ksel_pkg::WEIGHT_W-1:0] grp_wt_in  [G];

   logic [G-1:0]                         scan_ok;
   logic [ksel_pkg::SLOT_W-1:0]          scan_idx [G];
   logic [ksel_pkg::ID_W-1:0]            scan_id  [G];
   logic signed [ksel_pkg::WEIGHT_W-1:0] scan_wt  [G];

   logic                                 fin_ok;
   logic [ksel_pkg::SLOT_W-1:0]          fin_idx;
   logic [ksel_pkg::ID_W-1:0]            fin_id;
   logic signed [ksel_pkg::WEIGHT_W-1:0] fin_wt;

   logic                                 last_pick;

   assign csr_ready = 1'b1;
   assign last_pick = (cnt_ff == ksel_pkg::CNT_W'(K - 1));

   // First level of the tree: best slot within each group. During an update the
   // largest weight wins (lowest slot on ties); during a drain the smallest key
   // among slots not yet sent wins.
   always_comb begin
      int  g;
      logic drain;
      logic cand;
      logic better;
      drain = (state_ff == ksel_pkg::ST_DRAIN_SCAN);
      for (int j = 0; j < G; j++) begin
         scan_ok[j]  = 1'b0;
         scan_idx[j] = '0;
         scan_id[j]  = '0;
         scan_wt[j]  = '0;
      end
      for (int i = 0; i < K; i++) begin
         g      = i / ksel_pkg::GROUP_SIZE;
         cand   = drain ? !taken_ff[i] : 1'b1;
         better = drain ? ksel_pkg::key_less(slot_wt_ff[i], slot_id_ff[i],
                                             scan_wt[g], scan_id[g])
                        : ($signed(slot_wt_ff[i]) > $signed(scan_wt[g]));
         if (cand && (!scan_ok[g] || better)) begin
            scan_ok[g]  = 1'b1;
            scan_idx[g] = ksel_pkg::SLOT_W'(i);
            scan_id[g]  = slot_id_ff[i];
            scan_wt[g]  = slot_wt_ff[i];
         end
      end
   end

   // Second level of the tree over the registered group winners.
   always_comb begin
      logic drain;
      logic better;
      drain   = (state_ff == ksel_pkg::ST_DRAIN_PICK);
      fin_ok  = 1'b0;
      fin_idx = '0;
      fin_id  = '0;
      fin_wt  = '0;
      for (int j = 0; j < G; j++) begin
         better = drain ? ksel_pkg::key_less(grp_wt_ff[j], grp_id_ff[j], fin_wt, fin_id)
                        : ($signed(grp_wt_ff[j]) > $signed(fin_wt));
         if (grp_ok_ff[j] && (!fin_ok || better)) begin
            fin_ok  = 1'b1;
            fin_idx = grp_idx_ff[j];
            fin_id  = grp_id_ff[j];
            fin_wt  = grp_wt_ff[j];
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      empty_weight_in = csr_valid ? csr_empty_weight : empty_weight_ff;
      slot_id_in      = slot_id_ff;
      slot_wt_in      = slot_wt_ff;
      hit_in          = hit_ff;
      taken_in        = taken_ff;
      cnt_in          = cnt_ff;
      grp_ok_in       = grp_ok_ff;
      grp_idx_in      = grp_idx_ff;
      grp_id_in       = grp_id_ff;
      grp_wt_in       = grp_wt_ff;
      cmd_pop         = 1'b0;
      out_push        = 1'b0;
      out_data.rank   = ksel_pkg::RANK_W'(cnt_ff);
      out_data.id     = fin_id;
      out_data.weight = fin_wt;
      out_data.last   = last_pick;

      case (state_ff)
         ksel_pkg::ST_EVAL: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               op_in   = cmd_data;
               for (int i = 0; i < K; i++) begin
                  hit_in[i] = (slot_id_ff[i] == cmd_data.id);
               end
               grp_ok_in  = scan_ok;
               grp_idx_in = scan_idx;
               grp_id_in  = scan_id;
               grp_wt_in  = scan_wt;
               state_in   = ksel_pkg::ST_UPDATE;
            end
         end
         ksel_pkg::ST_UPDATE: begin
            if (op_ff.update) begin
               if (|hit_ff) begin
                  for (int i = 0; i < K; i++) begin
                     if (hit_ff[i] && ($signed(op_ff.weight) < $signed(slot_wt_ff[i]))) begin
                        slot_wt_in[i] = op_ff.weight;
                     end
                  end
               end else if ($signed(op_ff.weight) < $signed(fin_wt)) begin
                  slot_id_in[fin_idx] = op_ff.id;
                  slot_wt_in[fin_idx] = op_ff.weight;
               end
            end
            if (op_ff.last) begin
               taken_in = '0;
               cnt_in   = '0;
               state_in = ksel_pkg::ST_DRAIN_SCAN;
            end else begin
               state_in = ksel_pkg::ST_EVAL;
            end
         end
         ksel_pkg::ST_DRAIN_SCAN: begin
            grp_ok_in  = scan_ok;
            grp_idx_in = scan_idx;
            grp_id_in  = scan_id;
            grp_wt_in  = scan_wt;
            state_in   = ksel_pkg::ST_DRAIN_PICK;
         end
         ksel_pkg::ST_DRAIN_PICK: begin
            if (!out_full) begin
               out_push          = 1'b1;
               taken_in[fin_idx] = 1'b1;
               cnt_in            = cnt_ff + ksel_pkg::CNT_W'(1);
               if (last_pick) begin
                  for (int i = 0; i < K; i++) begin
                     slot_id_in[i] = '0;
                     slot_wt_in[i] = empty_weight_ff;
                  end
                  state_in = ksel_pkg::ST_EVAL;
               end else begin
                  state_in = ksel_pkg::ST_DRAIN_SCAN;
               end
            end
         end
         default: begin
            state_in = ksel_pkg::ST_EVAL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ksel_pkg::ST_EVAL;
         empty_weight_ff <= ksel_pkg::EMPTY_WEIGHT_RESET;
         taken_ff        <= '0;
         cnt_ff          <= '0;
         for (int i = 0; i < K; i++) begin
            slot_id_ff[i] <= '0;
            slot_wt_ff[i] <= ksel_pkg::EMPTY_WEIGHT_RESET;
         end
      end else begin
         state_ff        <= state_in;
         empty_weight_ff <= empty_weight_in;
         taken_ff        <= taken_in;
         cnt_ff          <= cnt_in;
         slot_id_ff      <= slot_id_in;
         slot_wt_ff      <= slot_wt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      hit_ff     <= hit_in;
      grp_ok_ff  <= grp_ok_in;
      grp_idx_ff <= grp_idx_in;
      grp_id_ff  <= grp_id_in;
      grp_wt_ff  <= grp_wt_in;
   end

   // An update always follows the evaluation of the same candidate.
   a_update_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksel_pkg::ST_UPDATE) |-> ($past(state_ff) == ksel_pkg::ST_EVAL))
      else $error("update without a preceding evaluation");

   // Identifiers are unique among filled slots, so at most one slot matches.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksel_pkg::ST_UPDATE && op_ff.update) |-> $onehot0(hit_ff))
      else $error("candidate matched more than one slot");

   // While draining there is always a slot left to send.
   a_pick_has_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ksel_pkg::ST_DRAIN_PICK) |-> fin_ok)
      else $error("drain pick found no remaining slot");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result pushed into a full queue");

   // The final result of a drain returns the engine to candidate processing.
   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (out_push && out_data.last) |=> (state_ff == ksel_pkg::ST_EVAL && taken_ff == '1))
      else $error("drain did not finish cleanly");

endmodule

### sv/ksel_rsp_queue.sv
// Result queue: buffers drained slots so the engine can keep draining while results wait, until the queue is full.
module ksel_rsp_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 out_push,
   input  ksel_pkg::rsp_type                    out_data,
   output logic                                 out_full,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [ksel_pkg::RANK_W-1:0]          rsp_rank,
   output logic [ksel_pkg::ID_W-1:0]            rsp_result_id,
   output logic signed [ksel_pkg::WEIGHT_W-1:0] rsp_result_weight,
   output logic                                 rsp_last_result
);

   ksel_pkg::rsp_type                queue_ff [ksel_pkg::RSP_DEPTH];
   logic [ksel_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ksel_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ksel_pkg::RSP_CNT_W-1:0]   count_ff, count_in;
   ksel_pkg::rsp_type                head;
   logic                             push_ok;
   logic                             pop_ok;

   assign out_full  = (count_ff == ksel_pkg::RSP_CNT_W'(ksel_pkg::RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign push_ok   = out_push && !out_full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   assign head              = queue_ff[rd_ptr_ff];
   assign rsp_rank          = head.rank;
   assign rsp_result_id     = head.id;
   assign rsp_result_weight = head.weight;
   assign rsp_last_result   = head.last;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == ksel_pkg::RSP_PTR_W'(ksel_pkg::RSP_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ksel_pkg::RSP_PTR_W'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == ksel_pkg::RSP_PTR_W'(ksel_pkg::RSP_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ksel_pkg::RSP_PTR_W'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + ksel_pkg::RSP_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - ksel_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= out_data;
      end
   end

endmodule

### sv/k_smallest_select.sv
// Top level of the k-smallest selection block: front end, slot engine and result queue.
//
// This block keeps the sixteen candidates with the smallest signed Q16.16 weights out of a
// stream of candidate requests and, on the request marked last, delivers them in ascending
// weight order (smaller identifier first on equal weights), one result per slot, with rank
// counting from 0 and last_result set on the sixteenth. Slots that were never filled come
// out with identifier 0 and the empty weight. A request that is excluded, or whose
// identifier is 0 or above 4096, changes nothing but still starts the drain if it is the
// last one. Requests enter a four-deep queue, so the input side keeps accepting while the
// engine works or the result side stalls. The slot engine takes one candidate at a time:
// an evaluation state does the identifier match and the first level of the maximum search
// over the slots, then an update state does the second level of that search and the slot
// write. For each result the drain runs a two-level minimum search over the slots not yet
// sent, in a scan state and then a pick state that waits while the result side is full; a
// two-entry result queue holds results until they are
// popped. The empty weight register resets to
// 1000.0 and a new value applies from the slot clear that ends the next drain. It may be
// written only while the block is idle, and the configuration port is always ready.
module k_smallest_select (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [ksel_pkg::ID_W-1:0]            req_candidate_id,
   input  logic signed [ksel_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                                 req_excluded,
   input  logic                                 req_last_candidate,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [ksel_pkg::RANK_W-1:0]          rsp_rank,
   output logic [ksel_pkg::ID_W-1:0]            rsp_result_id,
   output logic signed [ksel_pkg::WEIGHT_W-1:0] rsp_result_weight,
   output logic                                 rsp_last_result,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic signed [ksel_pkg::WEIGHT_W-1:0] csr_empty_weight
);

   // Classified candidates waiting for the slot engine.
   logic              cmd_valid;
   logic              cmd_pop;
   ksel_pkg::cmd_type cmd_data;

   // Drained results on their way to the result queue.
   logic              out_push;
   logic              out_full;
   ksel_pkg::rsp_type out_data;

   ksel_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_candidate_id   (req_candidate_id),
      .req_weight         (req_weight),
      .req_excluded       (req_excluded),
      .req_last_candidate (req_last_candidate),
      .cmd_valid          (cmd_valid),
      .cmd_data           (cmd_data),
      .cmd_pop            (cmd_pop)
   );

   ksel_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_empty_weight (csr_empty_weight),
      .cmd_valid        (cmd_valid),
      .cmd_data         (cmd_data),
      .cmd_pop          (cmd_pop),
      .out_full         (out_full),
      .out_push         (out_push),
      .out_data         (out_data)
   );

   ksel_rsp_queue u_rsp_queue (
      .clock             (clock),
      .reset             (reset),
      .out_push          (out_push),
      .out_data          (out_data),
      .out_full          (out_full),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_rank          (rsp_rank),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_weight (rsp_result_weight),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
